// ===== rtl/aat_pkg.sv =====
// ---------------------------------------------------------------------------
// Aging address table package
// Shared types, sizes and event codes for the aging device address table.
// ---------------------------------------------------------------------------
`default_nettype none

package aat_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Timeout after reset, in milliseconds.
    localparam logic [31:0] TIMEOUT_RESET = 32'(15 * 1000);

    // Event codes carried in event_kind.
    localparam logic [1:0] EV_REFRESH = 2'd0;
    localparam logic [1:0] EV_ADDED   = 2'd1;
    localparam logic [1:0] EV_IGNORED = 2'd2;
    localparam logic [1:0] EV_REMOVED = 2'd3;

    // One sighting.
    typedef struct packed {
        logic [47:0] dev_addr;
        logic [1:0]  addr_kind;
        logic [31:0] now_ms;
    } item_t;

    // One reported event.
    typedef struct packed {
        logic [1:0]  event_kind;
        logic [47:0] ev_addr;
        logic [1:0]  ev_addr_kind;
        logic [31:0] ev_time_ms;
        logic [4:0]  active_count;
        logic        last_of_run;
    } result_t;

    // One stored table entry.
    typedef struct packed {
        logic [47:0] addr;
        logic [1:0]  kind;
        logic [31:0] seen;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic hit;
        logic scan_inc;
        logic upd;
        logic keep;
        logic remove;
        logic flush;
    } aat_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_end;
        logic match;
        logic expired;
        logic out_free;
    } aat_sts_t;

endpackage

`default_nettype wire

// ===== rtl/aat_dp.sv =====
// ---------------------------------------------------------------------------
// Aging address table datapath
// Entry storage, scan and write pointers, pending event and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module aat_dp (
    input  wire                  clk,
    input  wire                  rst_n,
    input  aat_pkg::item_t       item,
    input  wire                  result_stall,
    output aat_pkg::result_t     result,
    output logic                 result_valid,
    input  wire                  cfg_valid,
    input  wire                  cfg_ready,
    input  wire  [31:0]          cfg_data,
    input  aat_pkg::aat_cmd_t    cmd,
    output aat_pkg::aat_sts_t    sts
);
    import aat_pkg::*;

    entry_t            entry_mem [TABLE_DEPTH];
    item_t             item_reg;
    result_t           pend_reg, pend_next;
    result_t           out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       timeout_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  live_reg, live_next;
    logic [CNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]  wr_idx_reg, wr_idx_next;
    logic              hit_reg, hit_next;
    entry_t            rd_entry;
    entry_t            wr_data;
    logic [IDX_W-1:0]  wr_addr;
    logic              wr_en;
    logic [31:0]       age;

    // Entry under the scan pointer and its age.
    assign rd_entry = entry_mem[scan_idx_reg[IDX_W-1:0]];
    assign age      = item_reg.now_ms - rd_entry.seen;

    assign sts.scan_end = (scan_idx_reg == count_reg);
    assign sts.match    = (rd_entry.addr == item_reg.dev_addr) &&
                          (rd_entry.kind == item_reg.addr_kind);
    assign sts.expired  = (age > timeout_reg);
    assign sts.out_free = !out_valid_reg || !result_stall;

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    // Single write port: refresh or append on update, compaction on keep.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = wr_idx_reg[IDX_W-1:0];
        wr_data = rd_entry;
        if (cmd.upd)
        begin
            wr_data = '{addr: item_reg.dev_addr, kind: item_reg.addr_kind,
                        seen: item_reg.now_ms};
            if (hit_reg)
            begin
                wr_en   = 1'b1;
                wr_addr = scan_idx_reg[IDX_W-1:0];
            end
            else if (count_reg < CNT_W'(TABLE_DEPTH))
            begin
                wr_en   = 1'b1;
                wr_addr = count_reg[IDX_W-1:0];
            end
        end
        else if (cmd.keep)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
    end

    // Pointers, counts, pending event and output register.
    always_comb
    begin
        count_next     = count_reg;
        live_next      = live_reg;
        scan_idx_next  = scan_idx_reg;
        wr_idx_next    = wr_idx_reg;
        hit_next       = hit_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;

        if (cmd.load)
        begin
            scan_idx_next = '0;
            wr_idx_next   = '0;
            hit_next      = 1'b0;
        end
        if (cmd.hit)
        begin
            hit_next = 1'b1;
        end
        if (cmd.scan_inc)
        begin
            scan_idx_next = scan_idx_reg + CNT_W'(1);
        end

        // Update outcome becomes the first pending event.
        if (cmd.upd)
        begin
            pend_next.ev_addr      = item_reg.dev_addr;
            pend_next.ev_addr_kind = item_reg.addr_kind;
            pend_next.ev_time_ms   = item_reg.now_ms;
            pend_next.last_of_run  = 1'b0;
            live_next              = count_reg;
            if (hit_reg)
            begin
                pend_next.event_kind = EV_REFRESH;
            end
            else if (count_reg < CNT_W'(TABLE_DEPTH))
            begin
                pend_next.event_kind = EV_ADDED;
                count_next           = count_reg + CNT_W'(1);
                live_next            = count_reg + CNT_W'(1);
            end
            else
            begin
                pend_next.event_kind = EV_IGNORED;
                pend_next.ev_time_ms = '0;
            end
            pend_next.active_count = 5'(live_next);
            scan_idx_next          = '0;
            wr_idx_next            = '0;
        end

        // Survivor moves down to the write pointer.
        if (cmd.keep)
        begin
            wr_idx_next   = wr_idx_reg + CNT_W'(1);
            scan_idx_next = scan_idx_reg + CNT_W'(1);
        end

        // Removal: the previous pending event goes out, this one waits.
        if (cmd.remove)
        begin
            out_next               = pend_reg;
            out_next.last_of_run   = 1'b0;
            out_valid_next         = 1'b1;
            live_next              = live_reg - CNT_W'(1);
            pend_next.event_kind   = EV_REMOVED;
            pend_next.ev_addr      = rd_entry.addr;
            pend_next.ev_addr_kind = rd_entry.kind;
            pend_next.ev_time_ms   = rd_entry.seen;
            pend_next.active_count = 5'(live_reg - CNT_W'(1));
            pend_next.last_of_run  = 1'b0;
            scan_idx_next          = scan_idx_reg + CNT_W'(1);
        end

        // End of the pass: the last event closes the run.
        if (cmd.flush)
        begin
            out_next             = pend_reg;
            out_next.last_of_run = 1'b1;
            out_valid_next       = 1'b1;
            count_next           = live_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            live_reg      <= '0;
            scan_idx_reg  <= '0;
            wr_idx_reg    <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            timeout_reg   <= TIMEOUT_RESET;
        end
        else
        begin
            count_reg     <= count_next;
            live_reg      <= live_next;
            scan_idx_reg  <= scan_idx_next;
            wr_idx_reg    <= wr_idx_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                timeout_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

`ifndef SYNTHESIS
    // The table never holds more entries than it has rows.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    // Compaction never writes ahead of the entry being examined.
    a_wr_behind: assert property (@(posedge clk) disable iff (!rst_n)
        wr_idx_reg <= scan_idx_reg)
        else $error("compaction write pointer passed scan pointer");

    // At the end of a pass the live count equals the survivors written.
    a_flush_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |-> (live_reg == wr_idx_reg))
        else $error("live count disagrees with compacted entries");

    // A removal always takes an entry that is held.
    a_remove_live: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.remove |-> (live_reg != '0))
        else $error("removal with an empty table");
`endif

endmodule

`default_nettype wire

// ===== rtl/aat_ctrl.sv =====
// ---------------------------------------------------------------------------
// Aging address table controller
// Sequences search, update, aging pass and final flush for each sighting.
// ---------------------------------------------------------------------------
`default_nettype none

module aat_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  item_valid,
    output logic                 item_stall,
    input  aat_pkg::aat_sts_t    sts,
    output aat_pkg::aat_cmd_t    cmd
);
    import aat_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SRCH  = 3'd1;
    localparam logic [2:0] ST_UPD   = 3'd2;
    localparam logic [2:0] ST_AGE   = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    logic [2:0] state_reg, state_next;

    // Sightings are taken only between runs.
    assign item_stall = (state_reg != ST_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH:
            begin
                if (sts.scan_end)
                begin
                    state_next = ST_UPD;
                end
                else if (sts.match)
                begin
                    cmd.hit    = 1'b1;
                    state_next = ST_UPD;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                end
            end
            ST_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = ST_AGE;
            end
            ST_AGE:
            begin
                if (sts.scan_end)
                begin
                    state_next = ST_FLUSH;
                end
                else if (!sts.expired)
                begin
                    cmd.keep = 1'b1;
                end
                else if (sts.out_free)
                begin
                    cmd.remove = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/aging_device_address_table_core.sv =====
// ---------------------------------------------------------------------------
// Aging device address table
// Tracks recently seen devices, refreshes or appends on each sighting and
// ages out stale entries, reporting the outcome of each sighting and each removal.
// ---------------------------------------------------------------------------
// Each sighting (address, address type, time in ms) is searched in an ordered
// table of 16 entries: a hit refreshes the entry's time, a miss appends it if
// there is room and is otherwise reported as ignored. An aging pass then
// removes, in table order, every entry older than timeout_ms (wrap-around
// age), closing the gaps. The first result is the update outcome, followed by
// one result per removal; last_of_run marks the final one. One sighting is
// processed at a time: the search examines the entries in table order until
// a hit or the end of the table, then come the update, the aging pass over
// every entry held after the update, and the flush; the next sighting is
// taken in the idle state that follows. Removals and the flush wait while
// the result side stalls, so the next sighting is then taken later. The
// timeout register is always ready to be written and should be changed only
// while idle.
`default_nettype none

module aging_device_address_table_core (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                item_valid,
    output logic               item_stall,
    input  aat_pkg::item_t     item,
    output logic               result_valid,
    input  wire                result_stall,
    output aat_pkg::result_t   result,
    input  wire                cfg_valid,
    output logic               cfg_ready,
    input  wire  [31:0]        cfg_data
);
    import aat_pkg::*;

    aat_cmd_t cmd;
    aat_sts_t sts;

    assign cfg_ready = 1'b1;

    // Sequencer.
    aat_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // Table storage and result path.
    aat_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .result_stall (result_stall),
        .result       (result),
        .result_valid (result_valid),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

`default_nettype wire

// ===== tb/sv/aging_device_address_table_core_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Aging device address table testbench
// Sends sightings through the table under several timeout settings, predicts
// every reported event with a local model of the table and compares each
// event beat, field by field, in order against the predictions.
// ---------------------------------------------------------------------------

module aging_device_address_table_core_tb;

    import aat_pkg::*;

    localparam int POOL_SIZE   = 22;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE      = 40;

    // Clock, reset and block ports.
    logic        clk;
    logic        rst_n          = 1'b0;
    logic        sighting_valid = 1'b0;
    logic        sighting_stall;
    item_t       sighting       = '0;
    logic        event_valid;
    logic        event_stall    = 1'b0;
    result_t     event_beat;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data       = '0;

    // Sightings waiting to be sent and events waiting to be seen.
    item_t       sightings_to_send [$];
    result_t     expected_events [$];
    int unsigned sightings_queued   = 0;
    int unsigned sightings_accepted = 0;
    int unsigned mismatches         = 0;

    // Flow control between the stimulus sequence and the two ports.
    logic        no_idle       = 1'b0;
    int          hold_requests = 0;
    int          holds_done    = 0;
    int          hold_left     = 0;
    int          quiet_cycles  = 0;

    // Local copy of the table and the timeout register.
    logic [47:0] tbl_addr [TABLE_DEPTH];
    logic [1:0]  tbl_kind [TABLE_DEPTH];
    logic [31:0] tbl_seen [TABLE_DEPTH];
    int          tbl_count   = 0;
    logic [31:0] cur_timeout = TIMEOUT_RESET;

    // Devices that recur in the random traffic.
    logic [47:0] pool_addr [POOL_SIZE];
    logic [1:0]  pool_kind [POOL_SIZE];
    logic [31:0] clock_ms;

    aging_device_address_table_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (sighting_valid),
        .item_stall   (sighting_stall),
        .item         (sighting),
        .result_valid (event_valid),
        .result_stall (event_stall),
        .result       (event_beat),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Update the local table for one sighting and queue the events it causes.
    function automatic void predict_sighting(input item_t s);
        result_t     ev;
        result_t     run [$];
        int          hit_idx;
        int          i;
        int          j;
        logic [31:0] age;
        hit_idx = -1;
        for (i = 0; i < tbl_count; i++)
        begin
            if (hit_idx < 0 && tbl_addr[i] == s.dev_addr && tbl_kind[i] == s.addr_kind)
                hit_idx = i;
        end
        ev = '0;
        ev.ev_addr      = s.dev_addr;
        ev.ev_addr_kind = s.addr_kind;
        if (hit_idx >= 0)
        begin
            tbl_seen[hit_idx] = s.now_ms;
            ev.event_kind = EV_REFRESH;
            ev.ev_time_ms = s.now_ms;
        end
        else if (tbl_count < TABLE_DEPTH)
        begin
            tbl_addr[tbl_count] = s.dev_addr;
            tbl_kind[tbl_count] = s.addr_kind;
            tbl_seen[tbl_count] = s.now_ms;
            tbl_count++;
            ev.event_kind = EV_ADDED;
            ev.ev_time_ms = s.now_ms;
        end
        else
        begin
            ev.event_kind = EV_IGNORED;
            ev.ev_time_ms = '0;
        end
        ev.active_count = 5'(tbl_count);
        run.push_back(ev);

        // Aging pass: drop stale entries and close the gaps in order.
        i = 0;
        while (i < tbl_count)
        begin
            age = s.now_ms - tbl_seen[i];
            if (age > cur_timeout)
            begin
                ev.event_kind   = EV_REMOVED;
                ev.ev_addr      = tbl_addr[i];
                ev.ev_addr_kind = tbl_kind[i];
                ev.ev_time_ms   = tbl_seen[i];
                for (j = i; j < tbl_count - 1; j++)
                begin
                    tbl_addr[j] = tbl_addr[j + 1];
                    tbl_kind[j] = tbl_kind[j + 1];
                    tbl_seen[j] = tbl_seen[j + 1];
                end
                tbl_count--;
                ev.active_count = 5'(tbl_count);
                run.push_back(ev);
            end
            else
            begin
                i++;
            end
        end
        run[run.size() - 1].last_of_run = 1'b1;
        foreach (run[k])
            expected_events.push_back(run[k]);
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void queue_sighting(input logic [47:0] addr, input logic [1:0] kind,
                                           input logic [31:0] t);
        item_t s;
        s.dev_addr  = addr;
        s.addr_kind = kind;
        s.now_ms    = t;
        sightings_to_send.push_back(s);
        sightings_queued++;
    endfunction

    // Sighting driver: predicts on each accepted beat, then offers the next one.
    always @(posedge clk)
    begin : send_sightings
        if (!rst_n)
        begin
            sighting_valid <= 1'b0;
        end
        else
        begin
            if (sighting_valid && !sighting_stall)
            begin
                predict_sighting(sighting);
                sightings_accepted++;
            end
            if (!sighting_valid || !sighting_stall)
            begin
                if (sightings_to_send.size() > 0 && (no_idle || $urandom_range(99) >= 18))
                begin
                    sighting       <= sightings_to_send.pop_front();
                    sighting_valid <= 1'b1;
                end
                else
                begin
                    sighting_valid <= 1'b0;
                end
            end
        end
    end

    // Event monitor: checks each accepted beat and drives the stall.
    always @(posedge clk)
    begin : check_events
        result_t want;
        if (!rst_n)
        begin
            event_stall <= 1'b0;
        end
        else
        begin
            if (event_valid && !event_stall)
            begin
                if (expected_events.size() == 0)
                begin
                    $display("%0t: unexpected event, expected none, actual %0h",
                             $time, event_beat);
                    mismatches++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    compare_field("event_kind", want.event_kind, event_beat.event_kind);
                    compare_field("ev_addr", want.ev_addr, event_beat.ev_addr);
                    compare_field("ev_addr_kind", want.ev_addr_kind, event_beat.ev_addr_kind);
                    compare_field("ev_time_ms", want.ev_time_ms, event_beat.ev_time_ms);
                    compare_field("active_count", want.active_count, event_beat.active_count);
                    compare_field("last_of_run", want.last_of_run, event_beat.last_of_run);
                end
            end

            // A requested hold keeps the block backed up for a long stretch.
            if (hold_left > 0)
            begin
                hold_left   <= hold_left - 1;
                event_stall <= 1'b1;
            end
            else if (holds_done != hold_requests)
            begin
                holds_done  <= holds_done + 1;
                hold_left   <= HOLD_CYCLES;
                event_stall <= 1'b1;
            end
            else
            begin
                event_stall <= !no_idle && ($urandom_range(99) < 18);
            end
        end
    end

    // Watchdog: ends the run when no beat moves on any channel for too long.
    always @(posedge clk)
    begin : watchdog
        if ((sighting_valid && !sighting_stall) || (event_valid && !event_stall) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("status: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Wait until every sighting is accepted and every event has arrived.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (sightings_accepted != sightings_queued || expected_events.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        cur_timeout = value;
    endtask

    // Random traffic: mostly recurring devices, some strangers and time jumps.
    task automatic queue_random_sightings(input int count, input int unsigned max_step);
        int          n;
        int          p;
        logic [47:0] a;
        logic [1:0]  kd;
        @(negedge clk);
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 5)
                clock_ms = $urandom;
            else
                clock_ms += $urandom_range(max_step);
            if ($urandom_range(99) < 78)
            begin
                p  = $urandom_range(POOL_SIZE - 1);
                a  = pool_addr[p];
                kd = pool_kind[p];
            end
            else
            begin
                a  = {16'($urandom), $urandom};
                kd = 2'($urandom);
            end
            queue_sighting(a, kd, clock_ms);
        end
    endtask

    initial
    begin : run_test
        int          k;
        logic [47:0] dev_x;
        logic [47:0] dev_y;
        logic [47:0] dev_z;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Recurring devices; some share an address under another type.
        for (k = 0; k < POOL_SIZE; k++)
        begin
            if (k % 4 == 1)
            begin
                pool_addr[k] = pool_addr[k - 1];
                pool_kind[k] = pool_kind[k - 1] + 2'd1;
            end
            else
            begin
                pool_addr[k] = {16'($urandom), $urandom};
                pool_kind[k] = 2'($urandom);
            end
        end
        dev_x = {16'($urandom), $urandom};
        dev_y = {16'($urandom), $urandom};
        dev_z = {16'($urandom), $urandom};

        // Directed part under the reset timeout: field extremes, a type that
        // differs under one address, refresh, filling up, a full table, the
        // exact timeout boundary, a full sweep and a wrapping clock.
        @(negedge clk);
        queue_sighting(48'h0, 2'd0, 32'd0);
        queue_sighting(48'hFFFF_FFFF_FFFF, 2'd3, 32'd1);
        queue_sighting(48'h0, 2'd1, 32'd2);
        queue_sighting(48'h0, 2'd0, 32'd100);
        for (k = 0; k < 13; k++)
            queue_sighting(pool_addr[k], pool_kind[k], 32'd200 + k);
        queue_sighting(48'hAAAA_5555_AAAA, 2'd2, 32'd300);
        queue_sighting(48'hFFFF_FFFF_FFFF, 2'd3, 32'd15100);
        queue_sighting(48'h5555_AAAA_5555, 2'd1, 32'd15101);
        queue_sighting(48'h1234_5678_9ABC, 2'd0, 32'd15102);
        queue_sighting(48'hAAAA_5555_AAAA, 2'd2, 32'd60000);
        queue_sighting(dev_x, 2'd1, 32'hFFFF_FFF0);
        queue_sighting(dev_x, 2'd1, 32'h0000_0010);
        queue_sighting(dev_y, 2'd2, 32'h0000_0020);
        queue_sighting(dev_z, 2'd3, 32'hFFFF_FF00);
        clock_ms = 32'hFFFF_FF00;
        wait_drained();

        // Zero timeout: only entries seen in the same millisecond survive.
        write_timeout(32'h0000_0000);
        queue_random_sightings(60, 2);
        wait_drained();

        // Largest timeout: nothing ages out, so the table fills up.
        write_timeout(32'hFFFF_FFFF);
        queue_random_sightings(100, 100000);
        wait_drained();

        // Short timeout with both sides running flat out.
        write_timeout(32'd300);
        @(posedge clk);
        no_idle <= 1'b1;
        queue_random_sightings(120, 60);
        wait_drained();
        no_idle <= 1'b0;

        // Back to the reset value, with the event side held off at the start.
        write_timeout(TIMEOUT_RESET);
        @(posedge clk);
        hold_requests <= hold_requests + 1;
        queue_random_sightings(120, 3000);
        wait_drained();

        // A random timeout to finish.
        write_timeout(32'($urandom_range(5000, 1)));
        queue_random_sightings(100, 1000);
        wait_drained();

        if (expected_events.size() != 0)
            $display("%0t: %0d expected events never arrived", $time, expected_events.size());
        if (mismatches == 0 && expected_events.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
